/* rtl/swsr_pkg.sv */
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared constants, codes and control types of the sliding-window sample ring.
// ----------------------------------------------------------------------------
package swsr_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int WINDOW_LEN = 64;
  localparam int WINDOW_HOP = 32;

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int K_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // Input word kinds.
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    ST_SAMPLE    = 2'd0,
    ST_NOTICE    = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_LAPPED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    write;       // store the input sample and bump the write count
    logic    put;         // load the result register
    status_t put_status;  // status of the loaded result
    logic    resync;      // jump the read position to the newest window
    logic    start;       // clear the window sample index
    logic    advance;     // step the window sample index
    logic    finish;      // close the window: count it and hop forward
  } swsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // result register can take a word this cycle
    logic notice;     // a write now completes the pending window
    logic short_fill; // fewer than a window of samples past the read position
    logic overrun;    // writer is more than a ring ahead of the read position
    logic k_last;     // window sample index is on the final sample
  } swsr_stat_t;

endpackage

/* rtl/swsr_if.sv */
// ----------------------------------------------------------------------------
// swsr_in_if / swsr_out_if
// Valid/ready channels carrying input words and result words of the ring.
// ----------------------------------------------------------------------------
interface swsr_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface swsr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] win_sample;
  logic               last;
  logic [31:0]        window_number;
  logic [31:0]        window_start;
  logic               after_resync;

  modport source (output valid, output status, output win_sample, output last,
                  output window_number, output window_start, output after_resync,
                  input ready);
  modport sink   (input valid, input status, input win_sample, input last,
                  input window_number, input window_start, input after_resync,
                  output ready);
endinterface

/* rtl/swsr_ctrl.sv */
// ----------------------------------------------------------------------------
// swsr_ctrl
// Controller: decodes input words and sequences the streaming of a window.
// ----------------------------------------------------------------------------
module swsr_ctrl
  import swsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  input  swsr_stat_t stat,
  output swsr_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.put_status = ST_SAMPLE;
    case (state)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_kind == KIND_WRITE) begin
            cmd.write = 1'b1;
            if (stat.notice) begin
              cmd.put        = 1'b1;
              cmd.put_status = ST_NOTICE;
            end
          end else if (stat.short_fill) begin
            cmd.put        = 1'b1;
            cmd.put_status = ST_NOT_READY;
          end else if (stat.overrun) begin
            cmd.put        = 1'b1;
            cmd.put_status = ST_LAPPED;
            cmd.resync     = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // The store read issued in this cycle lands in the read register.
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.put        = 1'b1;
          cmd.put_status = ST_SAMPLE;
          cmd.advance    = 1'b1;
          if (stat.k_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/swsr_dp.sv */
// ----------------------------------------------------------------------------
// swsr_dp
// Datapath: sample store, counters, fill level and the result register.
// ----------------------------------------------------------------------------
module swsr_dp
  import swsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] in_sample,
  input  swsr_cmd_t          cmd,
  output swsr_stat_t         stat,
  swsr_out_if.source         result
);

  logic [15:0]       mem [RING_DEPTH];
  logic [15:0]       rd_data;
  logic [ADDR_W-1:0] rd_addr;

  logic [31:0]  write_count;
  logic [31:0]  read_position;
  logic         resync_pending;
  logic [31:0]  windows_delivered;
  // Fill level is write_count - read_position, kept so that every check is
  // a compare against a constant.
  logic [31:0]  fill;
  logic [31:0]  fill_less;
  logic [K_W-1:0] k;

  logic         out_valid;
  status_t      out_status;
  logic [15:0]  out_sample;
  logic         out_last;
  logic [31:0]  out_number;
  logic [31:0]  out_start;
  logic         out_resync;

  assign rd_addr   = read_position[ADDR_W-1:0] + ADDR_W'(k);
  assign fill_less = fill - 32'(WINDOW_LEN);

  assign stat.out_free   = !out_valid || result.ready;
  assign stat.notice     = (fill == 32'(WINDOW_LEN - 1));
  assign stat.short_fill = fill_less[31];
  assign stat.overrun    = (fill > 32'(RING_DEPTH));
  assign stat.k_last     = (k == K_W'(WINDOW_LEN - 1));

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[write_count[ADDR_W-1:0]] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count       <= '0;
      read_position     <= '0;
      resync_pending    <= 1'b0;
      windows_delivered <= '0;
      fill              <= '0;
      k                 <= '0;
    end else begin
      if (cmd.write) begin
        write_count <= write_count + 32'd1;
        fill        <= fill + 32'd1;
      end
      if (cmd.resync) begin
        read_position  <= write_count - 32'(WINDOW_LEN);
        resync_pending <= 1'b1;
        fill           <= 32'(WINDOW_LEN);
      end
      if (cmd.start) begin
        k <= '0;
      end else if (cmd.advance) begin
        k <= k + K_W'(1);
      end
      if (cmd.finish) begin
        windows_delivered <= windows_delivered + 32'd1;
        resync_pending    <= 1'b0;
        read_position     <= read_position + 32'(WINDOW_HOP);
        fill              <= fill - 32'(WINDOW_HOP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_status <= cmd.put_status;
      out_sample <= (cmd.put_status == ST_SAMPLE) ? rd_data : 16'd0;
      out_last   <= (cmd.put_status != ST_SAMPLE) || stat.k_last;
      out_number <= windows_delivered;
      if (cmd.resync) begin
        out_start  <= write_count - 32'(WINDOW_LEN);
        out_resync <= 1'b1;
      end else begin
        out_start  <= read_position;
        out_resync <= resync_pending;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.win_sample    = out_sample;
  assign result.last          = out_last;
  assign result.window_number = out_number;
  assign result.window_start  = out_start;
  assign result.after_resync  = out_resync;

endmodule

/* rtl/sliding_window_sample_ring.sv */
// ----------------------------------------------------------------------------
// sliding_window_sample_ring
// Ring store of 16-bit audio samples that hands out overlapping windows.
// ----------------------------------------------------------------------------
// The item channel takes words of two kinds. A write word stores one signed
// sample in a 1024-entry ring and normally produces no result; the write that
// completes the pending window produces one ready-notice word instead. A
// request word produces one not-ready word, one overrun word (the read
// position then jumps to the newest full window and the next window carries
// the resync flag), or the 64 samples of the window, oldest first, after
// which the read position moves forward by 32 samples.
//
// Timing: writes stream at one word per clock while the result register is
// free. A notice, not-ready or overrun word appears in the cycle after its
// item is taken. Each window sample goes through the registered store read
// (S_FETCH) and then the load of the result register (S_EMIT), and the
// ring takes no new word until the last sample of the window has been
// loaded.
//
// Reset clears the counters, the read position and the resync flag; the
// store contents are left as they are. When the receiver stalls, the result
// word is held in its register and the block waits; a write that produces
// no result is still only taken once the result register can accept a word.
// ----------------------------------------------------------------------------
module sliding_window_sample_ring
  import swsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  swsr_in_if.sink    item,
  swsr_out_if.source result
);

  swsr_cmd_t  cmd;
  swsr_stat_t stat;

  // The controller decides what each word does; the datapath holds all state.
  swsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swsr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_sample (item.sample),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression of the sliding-window sample ring: sample writes
// and window requests go in through the item channel, and every result word
// is compared with a mirror of the ring that is kept inside this bench.
// ----------------------------------------------------------------------------
module testbench
  import swsr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling on the run, even with every word and gap at its worst.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Cycles that the receiver holds off once, to back the ring up to its input.
  localparam int          LONG_HOLD    = 400;
  // Quiet time after the last expected word. It covers more than one full window.
  localparam int          DRAIN_CYCLES = 300;
  localparam int          REPORT_MAX   = 10;

  // One result word as the ring should produce it.
  typedef struct {
    status_t            status;
    logic signed [15:0] smp;
    logic               last;
    logic [31:0]        number;
    logic [31:0]        start;
    logic               resync;
  } win_word_t;

  // One row of the directed plan. A row sends reps words of one kind. The
  // sample comes either from the row or from the random picker. Where
  // fixed_result is set, the row's single result is typed in here and is not
  // taken from the mirror.
  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    int                 reps;
    logic               random_fill;
    logic               fixed_result;
    status_t            status;
    logic [31:0]        number;
    logic [31:0]        start;
    logic               resync;
  } stim_row_t;

  // Directed plan. It reads the ring before any write, checks both sample
  // extremes, checks the notice and not-ready answers on both sides of the
  // window boundary, and delivers a window with the writer exactly one ring
  // ahead. Another 33 samples after that lap the reader, so the next request
  // must resync, and the next window must carry the resync flag.
  localparam int PLAN_ROWS = 19;
  localparam stim_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b1, ST_NOT_READY, 32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   16'sh7FFF,   1, 1'b0, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   16'sh8000,   1, 1'b0, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   16'sd0,      1, 1'b0, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   -16'sd1,     1, 1'b0, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   16'sd0,     59, 1'b1, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b1, ST_NOT_READY, 32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   16'sd0,      1, 1'b1, 1'b1, ST_NOTICE,    32'd0, 32'd0,    1'b0},
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b1, ST_NOT_READY, 32'd1, 32'd32,   1'b0},
    '{KIND_WRITE,   16'sd0,     31, 1'b1, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   16'sd0,      1, 1'b1, 1'b1, ST_NOTICE,    32'd1, 32'd32,   1'b0},
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   16'sd0,    992, 1'b1, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_WRITE,   16'sd0,     33, 1'b1, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b1, ST_LAPPED,    32'd3, 32'd1057, 1'b1},
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b0, ST_SAMPLE,    32'd0, 32'd0,    1'b0},
    '{KIND_REQUEST, 16'sd0,      1, 1'b1, 1'b1, ST_NOT_READY, 32'd4, 32'd1089, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  swsr_in_if  item_bus ();
  swsr_out_if result_bus ();

  sliding_window_sample_ring u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the ring: the store, the write count, the read position, the
  // resync flag and the number of windows handed out so far.
  logic [15:0] mirror_store [RING_DEPTH];
  logic [31:0] mirror_written   = '0;
  logic [31:0] mirror_read_pos  = '0;
  logic        mirror_resync    = 1'b0;
  logic [31:0] mirror_windows   = '0;

  // Result words still owed by the ring, oldest first.
  win_word_t due_words [$];

  int          mismatches  = 0;
  int unsigned cycle_count = 0;

  // steady and long_hold_pending are shared between the sender and the
  // receiver. When steady is set, neither side idles. When long_hold_pending
  // is set, the receiver takes one long hold-off.
  bit steady            = 1'b0;
  bit long_hold_pending = 1'b0;
  int send_gap_pct      = 15;

  // Queues one expected word. The window fields take the mirror state as it
  // stands when the word is made.
  function automatic void owe_word(status_t st, logic signed [15:0] smp, logic fin);
    win_word_t w;
    w = '{st, smp, fin, mirror_windows, mirror_read_pos, mirror_resync};
    due_words.push_back(w);
  endfunction

  // Applies one accepted word to the mirror and queues the results it causes.
  function automatic void step_ring_mirror(logic kind, logic signed [15:0] smp);
    logic [31:0] fill;
    logic [31:0] spare;
    logic [31:0] addr;
    if (kind == KIND_WRITE) begin
      mirror_store[mirror_written[ADDR_W-1:0]] = smp;
      mirror_written = mirror_written + 32'd1;
      // Only the write that lands exactly on a full window raises the notice.
      if (mirror_written == mirror_read_pos + 32'(WINDOW_LEN))
        owe_word(ST_NOTICE, 16'sd0, 1'b1);
    end else begin
      fill  = mirror_written - mirror_read_pos;
      spare = fill - 32'(WINDOW_LEN);
      if (spare[31]) begin
        owe_word(ST_NOT_READY, 16'sd0, 1'b1);
      end else if (fill > 32'(RING_DEPTH)) begin
        // The writer lapped the reader. Skip to the newest full window.
        mirror_read_pos = mirror_written - 32'(WINDOW_LEN);
        mirror_resync   = 1'b1;
        owe_word(ST_LAPPED, 16'sd0, 1'b1);
      end else begin
        for (int k = 0; k < WINDOW_LEN; k++) begin
          addr = mirror_read_pos + 32'(k);
          owe_word(ST_SAMPLE, mirror_store[addr[ADDR_W-1:0]], k == WINDOW_LEN - 1);
        end
        mirror_windows  = mirror_windows + 32'd1;
        mirror_resync   = 1'b0;
        mirror_read_pos = mirror_read_pos + 32'(WINDOW_HOP);
      end
    end
  endfunction

  // Picks a sample value. The full-scale and zero-crossing values come up
  // often, and any other value is possible.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one word and waits until the ring takes it. Everything is called at
  // a rising edge. A word that follows straight on keeps valid high, so valid
  // is never lowered and raised again within one step.
  task automatic send_word(logic kind, logic signed [15:0] smp);
    if (!steady && $urandom_range(1, 100) <= send_gap_pct) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_bus.valid  <= 1'b1;
    item_bus.kind   <= kind;
    item_bus.sample <= smp;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    step_ring_mirror(kind, smp);
  endtask

  // Sender: reset, the directed plan, then random traffic.
  initial begin : stimulus
    stim_row_t          row;
    win_word_t          typed_word;
    logic signed [15:0] smp;
    int                 rand_items;
    int                 burst;
    int                 pick;
    logic [31:0]        windows_at_start;
    bit                 lap_done;
    bit                 hold_done;

    rst             <= 1'b1;
    item_bus.valid  <= 1'b0;
    item_bus.kind   <= KIND_WRITE;
    item_bus.sample <= 16'sd0;
    rand_items = 0;
    lap_done   = 1'b0;
    hold_done  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = DIRECTED_PLAN[r];
      for (int n = 0; n < row.reps; n++) begin
        smp = row.random_fill ? pick_sample() : row.sample;
        send_word(row.kind, smp);
        if (row.fixed_result) begin
          // The typed-in answer replaces the mirror's word for this row.
          void'(due_words.pop_back());
          typed_word = '{row.status, 16'sd0, 1'b1, row.number, row.start, row.resync};
          due_words.push_back(typed_word);
        end
      end
    end

    // Random traffic. Most of it is a run of writes followed by a request,
    // which keeps the reader roughly in step with the writer so that windows
    // keep coming. The rest is stray requests and write runs with no request.
    // One long run of writes laps the reader so that a resync happens here too.
    windows_at_start = mirror_windows;
    while (rand_items < 150 || mirror_windows - windows_at_start < 8) begin
      // The final stretch runs with no idling on either side.
      if (rand_items >= 120)
        steady = 1'b1;
      if (!hold_done && rand_items >= 40) begin
        long_hold_pending = 1'b1;
        hold_done = 1'b1;
      end
      case ($urandom_range(0, 2))
        0:       send_gap_pct = 0;
        1:       send_gap_pct = 10;
        default: send_gap_pct = 35;
      endcase
      pick = $urandom_range(0, 9);
      if (!lap_done && rand_items >= 70) begin
        lap_done = 1'b1;
        repeat (RING_DEPTH + $urandom_range(6, 60)) send_word(KIND_WRITE, pick_sample());
        send_word(KIND_REQUEST, pick_sample());
        send_word(KIND_REQUEST, pick_sample());
      end else if (pick == 0) begin
        send_word(KIND_REQUEST, pick_sample());
        rand_items++;
      end else if (pick == 1) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_word(KIND_WRITE, pick_sample());
        rand_items += burst;
      end else begin
        burst = $urandom_range(4, 40);
        repeat (burst) send_word(KIND_WRITE, pick_sample());
        send_word(KIND_REQUEST, pick_sample());
        rand_items += burst + 1;
      end
    end
    item_bus.valid <= 1'b0;

    // Wait until every owed word has arrived. Then stay a while longer to
    // catch any stray words.
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("sliding_window_sample_ring regression: pass");
    end else begin
      $display("sliding_window_sample_ring regression: fail");
    end
    $finish;
  end

  // Receiver. It drops ready in bursts, with a stall rate that changes every
  // so often and is sometimes zero. Once it holds off for a long stretch, so
  // that the result register fills and the ring stops taking input.
  initial begin : result_sink
    int stall_pct;
    int span;
    int held;

    result_bus.ready <= 1'b0;
    stall_pct = 10;
    span      = 0;
    @(posedge clk);
    forever begin
      if (span == 0) begin
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
        span      = $urandom_range(50, 200);
      end
      span--;
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        result_bus.ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
      end else if (!steady && $urandom_range(1, 100) <= stall_pct) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        result_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Checks each accepted result word against the oldest owed word. Words are
  // sampled at the rising edge, so the values seen are the ones the handshake
  // used.
  always @(posedge clk) begin : result_check
    win_word_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (due_words.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result word: status %0d sample %0d last %0b start %0d",
                   result_bus.status, result_bus.win_sample, result_bus.last,
                   result_bus.window_start);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        if (result_bus.status        !== want.status ||
            result_bus.win_sample    !== want.smp    ||
            result_bus.last          !== want.last   ||
            result_bus.window_number !== want.number ||
            result_bus.window_start  !== want.start  ||
            result_bus.after_resync  !== want.resync) begin
          if (mismatches < REPORT_MAX) begin
            $display("result mismatch: status %0d/%0d sample %0d/%0d last %0b/%0b",
                     want.status, result_bus.status, want.smp, result_bus.win_sample,
                     want.last, result_bus.last);
            $display("  number %0d/%0d start %0d/%0d resync %0b/%0b (expected/actual)",
                     want.number, result_bus.window_number,
                     want.start, result_bus.window_start, want.resync,
                     result_bus.after_resync);
          end
          mismatches++;
        end
      end
    end
  end

  // Stops a run that hangs.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_window_sample_ring regression: fail");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/swsr_pkg.sv
rtl/swsr_if.sv
rtl/swsr_ctrl.sv
rtl/swsr_dp.sv
rtl/sliding_window_sample_ring.sv
sim/testbench.sv
